[design/rclfr_pkg.sv]
// Package for the radio-control link frame receiver.
// Holds codes, sizes and the CRC-8 byte update; no dependencies.
package rclfr_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] ADDR_SYNC_A = 8'hC8;
  localparam logic [7:0] ADDR_SYNC_B = 8'h00;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] TYPE_RC = 8'h16;
  localparam logic [7:0] TYPE_STAT = 8'h14;
  localparam logic [10:0] CHAN_MASK = 11'h7FF;
  localparam int MIN_TOTAL = 4;
  localparam int MIN_CHECKED_TOTAL = 5;
  localparam int RC_MIN_TOTAL = 22 + 4;
  localparam int STAT_MIN_TOTAL = 10 + 4;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [3:0] RC_LAST_CHAN = 4'd15;
  localparam logic [3:0] STAT_LAST_BYTE = 4'd9;
  localparam logic [7:0] PAYLOAD_BASE = 8'd3;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_LINE_ERR = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] KIND_CHAN = 2'd0;
  localparam logic [1:0] KIND_STAT = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR = 2'd2;
  localparam logic [1:0] KIND_LOST = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_LOST,
    ACT_RC,
    ACT_STAT
  } act_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] rd_off;
    logic       cap_en;
    logic [1:0] cap_slot;
    logic       load_out;
    logic       next_item;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic item_last;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[design/rclfr_in_if.sv]
// Input word channel of the frame receiver.
// Depends on nothing.
interface rclfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

// Result word channel of the frame receiver.
// Depends on nothing.
interface rclfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  item_index;
  logic [10:0] item_value;
  logic        last_of_run;
  logic        link_up;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (output valid, kind, item_index, item_value, last_of_run, link_up,
                  good_frames, bad_frames, input ready);
  modport sink (input valid, kind, item_index, item_value, last_of_run, link_up,
                good_frames, bad_frames, output ready);
endinterface

[design/rclfr_datapath.sv]
// Datapath: parser state, running CRC, frame store, counters and output register.
// Depends on rclfr_pkg; driven by rclfr_ctrl commands.
module rclfr_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rclfr_pkg::ctrl_cmd_t cmd,
  output rclfr_pkg::ctrl_stat_t stat,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_rx_byte,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [3:0]           out_item_index,
  output logic [10:0]          out_item_value,
  output logic                 out_last_of_run,
  output logic                 out_link_up,
  output logic [31:0]          out_good_frames,
  output logic [31:0]          out_bad_frames
);

  logic [7:0] mem [rclfr_pkg::MAX_FRAME_BYTES];

  logic [rclfr_pkg::POS_W-1:0] pos_r, pos_nxt, total_r, total_nxt, npos;
  logic [7:0] crc_r, crc_nxt, type_r, type_nxt, rd_data_r;
  logic link_r, link_nxt;
  logic [15:0] ticks_r, ticks_nxt, timeout_r, tick_inc;
  logic [31:0] good_r, good_nxt, bad_r, bad_nxt;
  rclfr_pkg::act_t act_r, act_nxt;
  logic [3:0] ch_r;
  logic [23:0] win_r;
  logic wr_en;
  logic [rclfr_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [9:0] tot_w;
  logic [7:0] bitpos, rd_sum;
  logic [23:0] shifted;
  logic [1:0] kind_w;
  logic [10:0] value_w;
  logic item_last_w;

  logic out_valid_r;
  logic [1:0] kind_r;
  logic [3:0] idx_r;
  logic [10:0] val_r;
  logic last_r, lup_r;
  logic [31:0] ogood_r, obad_r;

  always_comb begin
    pos_nxt = pos_r;
    total_nxt = total_r;
    crc_nxt = crc_r;
    type_nxt = type_r;
    link_nxt = link_r;
    ticks_nxt = ticks_r;
    good_nxt = good_r;
    bad_nxt = bad_r;
    act_nxt = act_r;
    wr_en = 1'b0;
    wr_addr = pos_r[rclfr_pkg::ADDR_W-1:0];
    tot_w = 10'(in_rx_byte) + 10'd2;
    npos = pos_r + 1'b1;
    tick_inc = (ticks_r < 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
    if (cmd.accept) begin
      act_nxt = rclfr_pkg::ACT_NONE;
      case (in_command)
        rclfr_pkg::CMD_BYTE: begin
          if (pos_r == '0) begin
            if (in_rx_byte == rclfr_pkg::ADDR_SYNC_A || in_rx_byte == rclfr_pkg::ADDR_SYNC_B) begin
              wr_en = 1'b1;
              pos_nxt = npos;
            end
          end else if (pos_r == rclfr_pkg::POS_W'(1)) begin
            wr_en = 1'b1;
            crc_nxt = '0;
            if (tot_w < 10'(rclfr_pkg::MIN_TOTAL) ||
                tot_w > 10'(rclfr_pkg::MAX_FRAME_BYTES)) begin
              pos_nxt = '0;
              total_nxt = '0;
            end else begin
              pos_nxt = npos;
              total_nxt = tot_w[rclfr_pkg::POS_W-1:0];
            end
          end else begin
            wr_en = 1'b1;
            if (pos_r == rclfr_pkg::POS_W'(2)) type_nxt = in_rx_byte;
            if (npos >= total_r) begin
              pos_nxt = '0;
              total_nxt = '0;
              if (total_r >= rclfr_pkg::POS_W'(rclfr_pkg::MIN_CHECKED_TOTAL)) begin
                if (crc_r != in_rx_byte) begin
                  bad_nxt = bad_r + 32'd1;
                  act_nxt = rclfr_pkg::ACT_ERR;
                end else if (type_r == rclfr_pkg::TYPE_RC &&
                             total_r >= rclfr_pkg::POS_W'(rclfr_pkg::RC_MIN_TOTAL)) begin
                  link_nxt = 1'b1;
                  ticks_nxt = '0;
                  good_nxt = good_r + 32'd1;
                  act_nxt = rclfr_pkg::ACT_RC;
                end else if (type_r == rclfr_pkg::TYPE_STAT &&
                             total_r >= rclfr_pkg::POS_W'(rclfr_pkg::STAT_MIN_TOTAL)) begin
                  act_nxt = rclfr_pkg::ACT_STAT;
                end
              end
            end else begin
              pos_nxt = npos;
              crc_nxt = rclfr_pkg::crc_byte(crc_r, in_rx_byte);
            end
          end
        end
        rclfr_pkg::CMD_TICK: begin
          ticks_nxt = tick_inc;
          if (link_r && tick_inc > timeout_r) begin
            link_nxt = 1'b0;
            act_nxt = rclfr_pkg::ACT_LOST;
          end
        end
        rclfr_pkg::CMD_LINE_ERR: begin
          pos_nxt = '0;
          total_nxt = '0;
          bad_nxt = bad_r + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      total_r <= '0;
      crc_r <= '0;
      type_r <= '0;
      link_r <= 1'b0;
      ticks_r <= '0;
      good_r <= '0;
      bad_r <= '0;
      act_r <= rclfr_pkg::ACT_NONE;
      timeout_r <= rclfr_pkg::TIMEOUT_RESET;
    end else begin
      pos_r <= pos_nxt;
      total_r <= total_nxt;
      crc_r <= crc_nxt;
      type_r <= type_nxt;
      link_r <= link_nxt;
      ticks_r <= ticks_nxt;
      good_r <= good_nxt;
      bad_r <= bad_nxt;
      act_r <= act_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
  end

  assign bitpos = {4'b0, ch_r} * 8'd11;
  assign rd_sum = (act_r == rclfr_pkg::ACT_STAT) ?
                  rclfr_pkg::PAYLOAD_BASE + {4'b0, ch_r} :
                  rclfr_pkg::PAYLOAD_BASE + {3'b0, bitpos[7:3]} + {6'b0, cmd.rd_off};
  assign rd_addr = rd_sum[rclfr_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_rx_byte;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) ch_r <= '0;
    else if (cmd.next_item) ch_r <= ch_r + 4'd1;
    if (cmd.cap_en) win_r[8*cmd.cap_slot +: 8] <= rd_data_r;
  end

  assign shifted = win_r >> bitpos[2:0];

  always_comb begin
    case (act_r)
      rclfr_pkg::ACT_RC: begin
        kind_w = rclfr_pkg::KIND_CHAN;
        value_w = shifted[10:0] & rclfr_pkg::CHAN_MASK;
        item_last_w = (ch_r == rclfr_pkg::RC_LAST_CHAN);
      end
      rclfr_pkg::ACT_STAT: begin
        kind_w = rclfr_pkg::KIND_STAT;
        value_w = {3'b0, win_r[7:0]};
        item_last_w = (ch_r == rclfr_pkg::STAT_LAST_BYTE);
      end
      rclfr_pkg::ACT_ERR: begin
        kind_w = rclfr_pkg::KIND_CRC_ERR;
        value_w = '0;
        item_last_w = 1'b1;
      end
      default: begin
        kind_w = rclfr_pkg::KIND_LOST;
        value_w = '0;
        item_last_w = 1'b1;
      end
    endcase
  end

  assign stat = {act_r, item_last_w, !out_valid_r || out_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_r <= kind_w;
      idx_r <= (kind_w == rclfr_pkg::KIND_CHAN || kind_w == rclfr_pkg::KIND_STAT) ? ch_r : 4'd0;
      val_r <= value_w;
      last_r <= item_last_w;
      lup_r <= link_r;
      ogood_r <= good_r;
      obad_r <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = kind_r;
  assign out_item_index = idx_r;
  assign out_item_value = val_r;
  assign out_last_of_run = last_r;
  assign out_link_up = lup_r;
  assign out_good_frames = ogood_r;
  assign out_bad_frames = obad_r;

endmodule

[design/rclfr_ctrl.sv]
// Controller: accepts words and sequences store reads and result loads.
// Depends on rclfr_pkg; drives rclfr_datapath.
module rclfr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rclfr_pkg::ctrl_stat_t stat,
  output rclfr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.act)
          rclfr_pkg::ACT_RC, rclfr_pkg::ACT_STAT: state_nxt = S_RD0;
          rclfr_pkg::ACT_ERR, rclfr_pkg::ACT_LOST: state_nxt = S_EMIT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD0: begin
        cmd.rd_off = 2'd0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd_off = 2'd1;
        cmd.cap_en = 1'b1;
        cmd.cap_slot = 2'd0;
        state_nxt = (stat.act == rclfr_pkg::ACT_STAT) ? S_EMIT : S_RD2;
      end
      S_RD2: begin
        cmd.rd_off = 2'd2;
        cmd.cap_en = 1'b1;
        cmd.cap_slot = 2'd1;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        cmd.cap_en = 1'b1;
        cmd.cap_slot = 2'd2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.item_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_item = 1'b1;
            state_nxt = S_RD0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/rc_link_frame_receiver_core.sv]
// Radio-control link frame receiver: accepts one word at a time, and no new word until the
// last one's results are loaded. A word causing one result loads it into the output register
// via the dispatch and emit states; a frame-ending word loads its channels or statistics one
// at a time, each after its store reads; output stalls hold the emit state.
// Synchronous active-low reset clears parser, counters and link state; timeout resets to 1000.
// Depends on rclfr_pkg, rclfr_in_if, rclfr_out_if, rclfr_ctrl and rclfr_datapath.
module rc_link_frame_receiver_core (
  input  logic         clk,
  input  logic         rst_n,
  rclfr_in_if.sink     in_ch,
  rclfr_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  rclfr_pkg::ctrl_cmd_t  cmd;
  rclfr_pkg::ctrl_stat_t stat;

  rclfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rclfr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_rx_byte      (in_ch.rx_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_item_index  (out_ch.item_index),
    .out_item_value  (out_ch.item_value),
    .out_last_of_run (out_ch.last_of_run),
    .out_link_up     (out_ch.link_up),
    .out_good_frames (out_ch.good_frames),
    .out_bad_frames  (out_ch.bad_frames)
  );

endmodule

[design/rclfr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
// Depends on rclfr_pkg and rc_link_frame_receiver_core.
module rclfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_item_index,
  input logic        out_last_of_run,
  input logic        out_link_up
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rclfr_pkg::KIND_CRC_ERR || out_kind == rclfr_pkg::KIND_LOST)
    |-> out_last_of_run)
    else $error("single result not marked last");

  a_lost_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rclfr_pkg::KIND_LOST |-> !out_link_up)
    else $error("link lost result with link up");

  a_chan_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rclfr_pkg::KIND_CHAN |-> out_link_up)
    else $error("channel result with link down");

  a_stat_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rclfr_pkg::KIND_STAT |-> out_item_index <= rclfr_pkg::STAT_LAST_BYTE)
    else $error("statistic index out of range");

endmodule

bind rc_link_frame_receiver_core rclfr_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_item_index  (out_ch.item_index),
  .out_last_of_run (out_ch.last_of_run),
  .out_link_up     (out_ch.link_up)
);

[bench/tb_scoreboard.sv]
// Scoreboard and predictor for the radio-control link frame receiver bench.
// Depends on rclfr_pkg for kind, command, sync and type codes, sizes and the reset timeout.
package tb_scoreboard_pkg;
  import rclfr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  item_index;
    logic [10:0] item_value;
    logic        last_of_run;
    logic        link_up;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } link_result_t;

  class link_scoreboard;
    logic [15:0] timeout_ticks;
    logic [6:0]  pos;
    logic [7:0]  total;
    logic [7:0]  frame [64];
    logic        link_on;
    logic [15:0] ticks;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    link_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      timeout_ticks = TIMEOUT_RESET;
      link_on = 0;
      ticks = 0;
      good_cnt = 0;
      bad_cnt = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      pos = 0;
      total = 0;
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    function void set_timeout(logic [15:0] v);
      timeout_ticks = v;
    endfunction

    function logic [7:0] frame_crc(int len);
      logic [7:0] c;
      c = 0;
      for (int i = 0; i < len; i++) begin
        c ^= frame[2 + i];
        for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
      end
      return c;
    endfunction

    function void note_word(logic [1:0] cmd, logic [7:0] byte_in);
      link_result_t run[$];
      link_result_t r;
      int len;
      int bitp;
      int bp;
      logic [23:0] w;
      r = '0;
      if (cmd == CMD_BYTE) begin
        if (pos == 0) begin
          if (byte_in == ADDR_SYNC_A || byte_in == ADDR_SYNC_B) begin
            frame[0] = byte_in;
            pos = 1;
          end
        end else if (pos == 1) begin
          frame[1] = byte_in;
          pos = 2;
          total = 8'(byte_in + 2);
          if (byte_in + 2 < MIN_TOTAL || byte_in + 2 > MAX_FRAME_BYTES) clear_parser();
        end else begin
          if (pos < MAX_FRAME_BYTES) frame[pos] = byte_in;
          pos++;
          if (pos >= total) begin
            len = int'(frame[1]);
            if (len + 2 >= MIN_CHECKED_TOTAL) begin
              if (frame_crc(len - 1) != frame[len + 1]) begin
                bad_cnt++;
                r.kind = KIND_CRC_ERR;
                run.push_back(r);
              end else if (frame[2] == TYPE_RC && len - 2 >= 22) begin
                for (int i = 0; i < 16; i++) begin
                  bitp = i * 11;
                  bp = 3 + (bitp >> 3);
                  w = {frame[bp + 2], frame[bp + 1], frame[bp]};
                  r.kind = KIND_CHAN;
                  r.item_index = 4'(i);
                  r.item_value = 11'(w >> (bitp & 7));
                  run.push_back(r);
                end
                link_on = 1;
                ticks = 0;
                good_cnt++;
              end else if (frame[2] == TYPE_STAT && len - 2 >= 10) begin
                for (int i = 0; i < 10; i++) begin
                  r.kind = KIND_STAT;
                  r.item_index = 4'(i);
                  r.item_value = {3'b0, frame[3 + i]};
                  run.push_back(r);
                end
              end
            end
            clear_parser();
          end else if (pos >= MAX_FRAME_BYTES) begin
            clear_parser();
          end
        end
      end else if (cmd == CMD_TICK) begin
        if (ticks != 16'hFFFF) ticks++;
        if (link_on && ticks > timeout_ticks) begin
          link_on = 0;
          r.kind = KIND_LOST;
          run.push_back(r);
        end
      end else if (cmd == CMD_LINE_ERR) begin
        clear_parser();
        bad_cnt++;
      end
      foreach (run[k]) begin
        run[k].last_of_run = (k == run.size() - 1);
        run[k].link_up = link_on;
        run[k].good_frames = good_cnt;
        run[k].bad_frames = bad_cnt;
        pending.push_back(run[k]);
      end
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
      end
    endfunction
  endclass
endpackage

[bench/tb_top.sv]
// Top of the frame receiver bench: clock, reset, word drivers and phases.
// Depends on rclfr_pkg, the channel interfaces, tb_scoreboard_pkg and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rclfr_pkg::*;
  import tb_scoreboard_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic stall_on;
  rclfr_in_if in_ch ();
  rclfr_out_if out_ch ();
  link_scoreboard sb;

  rc_link_frame_receiver_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.kind, out_ch.item_index, out_ch.item_value, out_ch.last_of_run,
                       out_ch.link_up, out_ch.good_frames, out_ch.bad_frames});
  end

  int stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!stall_on) out_ch.ready <= 1'b1;
    else out_ch.ready <= (stall_phase % 7 < 4) ? 1'b1 : ($urandom_range(0, 3) == 0);
  end

  task automatic send_word(logic [1:0] cmd, logic [7:0] b);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(cmd, b);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_timeout(v);
  endtask

  task automatic send_frame(logic [7:0] addr, logic [7:0] typ, int plen, bit bad_crc,
                            bit burst);
    logic [7:0] body[$];
    logic [7:0] c;
    body.push_back(typ);
    for (int i = 0; i < plen; i++) body.push_back(8'($urandom));
    c = 0;
    foreach (body[i]) begin
      c ^= body[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    if (bad_crc) c ^= 8'h01 << $urandom_range(0, 7);
    send_word(CMD_BYTE, addr);
    send_word(CMD_BYTE, 8'(plen + 2));
    foreach (body[i]) begin
      send_word(CMD_BYTE, body[i]);
      if (burst) gap();
    end
    send_word(CMD_BYTE, c);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(CMD_TICK, 8'h00);
  endtask

  task automatic random_phase(int items);
    int r;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_frame($urandom_range(0, 1) ? ADDR_SYNC_A : ADDR_SYNC_B, TYPE_RC,
                             $urandom_range(22, 30), $urandom_range(0, 5) == 0, 1);
      else if (r < 45) send_frame(ADDR_SYNC_A, TYPE_STAT, $urandom_range(10, 20),
                                  $urandom_range(0, 5) == 0, 1);
      else if (r < 52) send_frame(ADDR_SYNC_A, 8'($urandom), $urandom_range(0, 61), 0, 1);
      else if (r < 75) send_ticks($urandom_range(1, 8));
      else if (r < 80) send_word(CMD_LINE_ERR, 8'($urandom));
      else if (r < 83) send_word(CMD_UNUSED, 8'($urandom));
      else send_word(CMD_BYTE, 8'($urandom));
      gap();
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    stall_on = 0;
    stall_phase = 0;
    in_ch.valid = 0;
    in_ch.command = CMD_BYTE;
    in_ch.rx_byte = 0;
    out_ch.ready = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(ADDR_SYNC_A, TYPE_RC, 22, 0, 0);
    send_frame(ADDR_SYNC_B, TYPE_RC, 61, 0, 0);
    send_frame(ADDR_SYNC_A, TYPE_STAT, 10, 0, 0);
    send_frame(ADDR_SYNC_A, TYPE_RC, 22, 1, 0);
    send_frame(ADDR_SYNC_A, TYPE_RC, 21, 0, 0);
    send_frame(ADDR_SYNC_A, TYPE_STAT, 9, 0, 0);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, ADDR_SYNC_A);
    send_word(CMD_BYTE, 8'h01);
    send_word(CMD_BYTE, ADDR_SYNC_A);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, ADDR_SYNC_A);
    send_word(CMD_BYTE, 8'h02);
    send_word(CMD_BYTE, 8'hAA);
    send_word(CMD_BYTE, 8'h55);
    send_word(CMD_BYTE, ADDR_SYNC_A);
    send_word(CMD_BYTE, 8'h10);
    send_word(CMD_LINE_ERR, 8'hFF);
    send_word(CMD_UNUSED, 8'hFF);

    write_timeout(16'd0);
    send_frame(ADDR_SYNC_A, TYPE_RC, 22, 0, 0);
    send_ticks(2);

    stall_on = 1;
    write_timeout(16'd3);
    random_phase(3);

    write_timeout(16'd65534);
    random_phase(2);
    drain();
    random_phase(2);

    write_timeout(16'd10);
    stall_on = 0;
    random_phase(2);
    stall_on = 1;
    write_timeout(16'd1000);
    random_phase(2);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
